FILE: src/longest_palindrome_substring_core_assert.svh
// Assertion macros for the palindrome search RTL.
`ifndef LONGEST_PALINDROME_SUBSTRING_CORE_ASSERT_SVH
`define LONGEST_PALINDROME_SUBSTRING_CORE_ASSERT_SVH

// Implication checked in the same cycle.
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lps_pkg.sv
// Package with sizes and cell interface types for the palindrome search.
package lps_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam int START_W = 6;
    localparam int LEN_W   = 7;

    typedef struct packed {
        logic [7:0]       ch;
        logic [CNT_W-1:0] count;
        logic             take;
        logic             clear;
        logic [CNT_W-1:0] t1;
        logic [CNT_W-1:0] t2;
    } lps_bcast_t;

    typedef struct packed {
        logic hit1;
        logic hit2;
    } lps_hit_t;

endpackage

FILE: src/longest_palindrome_substring_core.sv
// Top level of the streaming longest palindromic substring search.
// One byte per cycle is sustained while results are taken.
// The result is registered and appears in the cycle after the final byte is accepted.
// Input stalls only while a finished result waits at the output.
// Every stored byte sits in its own cell, so all comparisons of one byte run in parallel.
// Reset, and the end of each string, clear marks, counters and the best match.
`include "longest_palindrome_substring_core_assert.svh"

module longest_palindrome_substring_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pal_start[5:0], pal_length[12:6], zero[15:13]
    output logic        m_tuser    // overflow[0]
);

    localparam int N = lps_pkg::MAX_LEN;

    logic                        s_acc;
    logic                        room;
    lps_pkg::lps_bcast_t         bc;
    logic [N:0]                  mark_chain;
    logic [N:0]                  written_chain;
    lps_pkg::lps_hit_t           hit_chain [N:0];
    logic [N-1:0]                mark_vec;
    logic [N-1:0]                written_vec;

    logic [lps_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [lps_pkg::IDX_W-1:0]   best_start_reg, best_start_next;
    logic [lps_pkg::CNT_W-1:0]   best_len_reg, best_len_next;
    logic                        ovf_reg, ovf_next;
    logic                        m_valid_reg, m_valid_next;
    logic [lps_pkg::START_W-1:0] out_start_reg, out_start_next;
    logic [lps_pkg::LEN_W-1:0]   out_len_reg, out_len_next;
    logic                        out_ovf_reg, out_ovf_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign room     = count_reg < lps_pkg::CNT_W'(N);

    assign bc.ch    = s_tdata;
    assign bc.count = count_reg;
    assign bc.take  = s_acc && room;
    assign bc.clear = s_acc && s_tlast;
    assign bc.t1    = count_reg - best_len_reg;
    assign bc.t2    = count_reg - best_len_reg - lps_pkg::CNT_W'(1);

    assign mark_chain[N]    = 1'b0;
    assign written_chain[N] = 1'b0;
    assign hit_chain[N]     = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            lps_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .idx        (lps_pkg::IDX_W'(g)),
                .bc         (bc),
                .mark_up    (mark_chain[g+1]),
                .written_up (written_chain[g+1]),
                .hit_in     (hit_chain[g+1]),
                .mark       (mark_vec[g]),
                .written    (written_vec[g]),
                .hit_out    (hit_chain[g])
            );
            assign mark_chain[g]    = mark_vec[g];
            assign written_chain[g] = written_vec[g];
        end
    endgenerate

    always_comb
    begin
        count_next      = count_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;

        if (s_acc)
        begin
            if (room)
            begin
                count_next = count_reg + lps_pkg::CNT_W'(1);
                if (hit_chain[0].hit2)
                begin
                    best_len_next   = best_len_reg + lps_pkg::CNT_W'(2);
                    best_start_next = lps_pkg::IDX_W'(bc.t2);
                end
                else if (hit_chain[0].hit1)
                begin
                    best_len_next   = best_len_reg + lps_pkg::CNT_W'(1);
                    best_start_next = lps_pkg::IDX_W'(bc.t1);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end

            if (s_tlast)
            begin
                m_valid_next    = 1'b1;
                out_start_next  = lps_pkg::START_W'(best_start_next);
                out_len_next    = lps_pkg::LEN_W'(best_len_next);
                out_ovf_next    = ovf_next;
                count_next      = '0;
                best_start_next = '0;
                best_len_next   = lps_pkg::CNT_W'(1);
                ovf_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            best_start_reg <= '0;
            best_len_reg   <= lps_pkg::CNT_W'(1);
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_start_reg};
    assign m_tuser  = out_ovf_reg;

    `LPS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= lps_pkg::CNT_W'(N), "byte count beyond string capacity")
    `LPS_ASSERT_NOW(a_best_fits, clk, rst_n, count_reg != '0,
        best_len_reg <= count_reg, "best match longer than stored string")
    `LPS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, s_acc && s_tlast,
        count_reg == '0 && best_len_reg == lps_pkg::CNT_W'(1), "state not cleared after final word")
    `LPS_ASSERT_NOW(a_result_source, clk, rst_n, $rose(m_valid_reg),
        $past(s_acc && s_tlast), "result raised without a final word")

endmodule

FILE: src/lps_cell.sv
// One stored byte of the string with its palindrome mark.
module lps_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [lps_pkg::IDX_W-1:0] idx,
    input  lps_pkg::lps_bcast_t       bc,
    input  logic                      mark_up,
    input  logic                      written_up,
    input  lps_pkg::lps_hit_t         hit_in,
    output logic                      mark,
    output logic                      written,
    output lps_pkg::lps_hit_t         hit_out
);

    logic [7:0]                char_reg;
    logic                      mark_reg;
    logic                      mark_next;
    logic                      is_new;
    logic [lps_pkg::CNT_W-1:0] idx_ext;

    assign idx_ext = lps_pkg::CNT_W'(idx);
    assign written = idx_ext < bc.count;
    assign is_new  = idx_ext == bc.count;
    assign mark    = mark_reg;

    always_comb
    begin
        if (is_new)
        begin
            mark_next = 1'b1;
        end
        else if (written)
        begin
            mark_next = (char_reg == bc.ch) && (!written_up || mark_up);
        end
        else
        begin
            mark_next = 1'b0;
        end
    end

    assign hit_out.hit1 = hit_in.hit1 |
                          (bc.take & written & mark_next & (idx_ext == bc.t1));
    assign hit_out.hit2 = hit_in.hit2 |
                          (bc.take & written & mark_next & (idx_ext == bc.t2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else if (bc.clear)
        begin
            mark_reg <= 1'b0;
        end
        else if (bc.take)
        begin
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.take && is_new)
        begin
            char_reg <= bc.ch;
        end
    end

endmodule

FILE: verif/tb_longest_palindrome_substring_core.sv
// Self-checking testbench for the streaming longest palindromic substring core.
module tb_longest_palindrome_substring_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_ROWS = 22;

    typedef struct packed {
        logic [5:0] start;
        logic [6:0] length;
        logic       ovf;
    } pal_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [6:0] reps;
        logic       fin;
        logic       typed;
        logic [5:0] start;
        logic [6:0] length;
        logic       ovf;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    pal_result_t awaited_results[$];
    int          mismatch_count;
    int          sent_count;
    int          stall_cycles;
    bit          calm;

    logic [7:0]  seen_bytes[lps_pkg::MAX_LEN];
    bit          pal_marks[lps_pkg::MAX_LEN];
    int unsigned bytes_held;
    int unsigned top_start;
    int unsigned top_length;
    bit          truncated;

    // Rows of one byte, a dropped final byte, exactly full, ties and even palindromes.
    stim_row_t dir_rows[DIR_ROWS] = '{
        '{8'h41, 7'd1,  1'b1, 1'b1, 6'd0, 7'd1,  1'b0},
        '{8'h00, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'hFF, 7'd1,  1'b1, 1'b1, 6'd0, 7'd1,  1'b0},
        '{8'hFF, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'hFF, 7'd1,  1'b1, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h61, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h62, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h61, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h62, 7'd1,  1'b1, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h61, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h61, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h62, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h62, 7'd1,  1'b1, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h61, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h62, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h63, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h63, 7'd1,  1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h62, 7'd1,  1'b1, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h80, 7'd64, 1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h80, 7'd1,  1'b1, 1'b1, 6'd0, 7'd64, 1'b1},
        '{8'h01, 7'd63, 1'b0, 1'b0, 6'd0, 7'd0,  1'b0},
        '{8'h01, 7'd1,  1'b1, 1'b1, 6'd0, 7'd64, 1'b0}
    };

    longest_palindrome_substring_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_string();
        for (int j = 0; j < lps_pkg::MAX_LEN; j++)
        begin
            pal_marks[j] = 1'b0;
        end
        bytes_held = 0;
        top_start = 0;
        top_length = 1;
        truncated = 1'b0;
    endfunction

    function automatic bit scan_byte(input logic [7:0] c, input logic fin,
                                     output pal_result_t res);
        int unsigned i;
        bit          inner;
        bit          mark;
        i = bytes_held;
        res = '0;
        if (i >= lps_pkg::MAX_LEN)
        begin
            truncated = 1'b1;
        end
        else
        begin
            // Ascending order keeps the previous column's mark j+1 intact until it is read.
            for (int unsigned j = 0; j < i; j++)
            begin
                inner = (i - j < 2) || pal_marks[j + 1];
                mark = (seen_bytes[j] == c) && inner;
                pal_marks[j] = mark;
                if (mark && (i - j + 1) > top_length)
                begin
                    top_length = i - j + 1;
                    top_start = j;
                end
            end
            pal_marks[i] = 1'b1;
            seen_bytes[i] = c;
            bytes_held = i + 1;
        end
        if (!fin)
        begin
            return 1'b0;
        end
        res.start = top_start[5:0];
        res.length = top_length[6:0];
        res.ovf = truncated;
        clear_string();
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] c, input logic fin, input logic typed,
                             input pal_result_t typed_res);
        pal_result_t res;
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (scan_byte(c, fin, res))
        begin
            awaited_results.insert(awaited_results.size(), typed ? typed_res : res);
        end
        sent_count++;
    endtask

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge clk)
    begin
        pal_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("Result word with no expectation: start %0d length %0d overflow %0d",
                       m_tdata[5:0], m_tdata[12:6], m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[5:0] !== want.start)
                begin
                    $error("pal_start: expected %0d, got %0d", want.start, m_tdata[5:0]);
                    mismatch_count++;
                end
                if (m_tdata[12:6] !== want.length)
                begin
                    $error("pal_length: expected %0d, got %0d", want.length, m_tdata[12:6]);
                    mismatch_count++;
                end
                if (m_tuser !== want.ovf)
                begin
                    $error("overflow: expected %0d, got %0d", want.ovf, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int         len;
        int         mode;
        int         p;
        int         e;
        int         lo;
        int         hi;
        logic [7:0] base;
        logic [7:0] str_buf[0:69];
        bit         paused;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        mismatch_count = 0;
        sent_count = 0;
        stall_cycles = 0;
        calm = 1'b0;
        paused = 1'b0;
        for (int j = 0; j < lps_pkg::MAX_LEN; j++)
        begin
            seen_bytes[j] = 8'h00;
        end
        clear_string();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
            begin
                push_byte(dir_rows[r].ch, dir_rows[r].fin && (k == dir_rows[r].reps - 1),
                          dir_rows[r].typed,
                          pal_result_t'({dir_rows[r].start, dir_rows[r].length,
                                         dir_rows[r].ovf}));
            end
        end

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            calm = (sent_count >= 300) && (sent_count < 450);
            if (!paused && sent_count >= 550)
            begin
                // Hold the input back until the output side has drained completely.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (awaited_results.size() != 0);
            end
            len = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 70) : $urandom_range(1, 20);
            mode = $urandom_range(0, 3);
            base = 8'($urandom);
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0: str_buf[k] = 8'($urandom);
                    1: str_buf[k] = base ^ 8'($urandom_range(0, 1));
                    2: str_buf[k] = base + 8'($urandom_range(0, 2));
                    default: str_buf[k] = 8'($urandom);
                endcase
            end
            if (mode == 3)
            begin
                p = $urandom_range(0, len - 1);
                e = $urandom_range(0, 1);
                for (int k = 0; k < len; k++)
                begin
                    lo = p - k;
                    hi = p + k + e;
                    if (lo < 0 || hi >= len)
                    begin
                        break;
                    end
                    str_buf[hi] = str_buf[lo];
                end
            end
            for (int k = 0; k < len; k++)
            begin
                push_byte(str_buf[k], k == len - 1, 1'b0, '0);
            end
        end

        calm = 1'b0;
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_results.size() != 0);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
